// ===== design/rsa_pkg.sv =====
// Shared types and constants of the region sector allocator.
`default_nettype none
package rsa_pkg;
  localparam int unsigned MaxSectors = 4096;
  localparam int unsigned SecW       = 12;
  localparam int unsigned ExtW       = 13;
  localparam int unsigned SlotW      = 10;
  localparam int unsigned LenW       = 8;
  localparam int unsigned FirstData  = 2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_CAP  = 2'd2;

  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic slot_rd;
    logic load_slot;
    logic scan_rd;
    logic scan_step;
    logic decide;
    logic rel_wr;
    logic claim_wr;
    logic commit;
    logic emit_zero;
    logic emit_cap;
  } rsa_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic n_zero;
    logic scan_empty;
    logic scan_last;
    logic found_now;
    logic cap_fail;
    logic rel_need;
    logic rel_done;
    logic claim_done;
    logic out_free;
  } rsa_sts_t;
endpackage
`default_nettype wire

// ===== design/rsa_ctrl.sv =====
// Controller FSM: clear, lookup, scan, release, claim, commit and error results.
`default_nettype none
module rsa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rsa_pkg::rsa_sts_t sts_i,
  output rsa_pkg::rsa_cmd_t      cmd_o
);
  import rsa_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_LOOKUP   = 4'd2;
  localparam logic [3:0] S_LOAD     = 4'd3;
  localparam logic [3:0] S_SCAN_RD  = 4'd4;
  localparam logic [3:0] S_SCAN_CHK = 4'd5;
  localparam logic [3:0] S_DECIDE   = 4'd6;
  localparam logic [3:0] S_REL      = 4'd7;
  localparam logic [3:0] S_CLAIM    = 4'd8;
  localparam logic [3:0] S_COMMIT   = 4'd9;
  localparam logic [3:0] S_ERR_ZERO = 4'd10;
  localparam logic [3:0] S_ERR_CAP  = 4'd11;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = sts_i.n_zero ? S_ERR_ZERO : S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd_o.slot_rd = 1'b1;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load_slot = 1'b1;
        state_d = sts_i.scan_empty ? S_DECIDE : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.found_now) state_d = sts_i.rel_need ? S_REL : S_CLAIM;
        else if (sts_i.scan_last) state_d = S_DECIDE;
        else state_d = S_SCAN_RD;
      end
      S_DECIDE: begin
        if (sts_i.cap_fail) begin
          state_d = S_ERR_CAP;
        end else begin
          cmd_o.decide = 1'b1;
          state_d = sts_i.rel_need ? S_REL : S_CLAIM;
        end
      end
      S_REL: begin
        cmd_o.rel_wr = 1'b1;
        if (sts_i.rel_done) state_d = S_CLAIM;
      end
      S_CLAIM: begin
        cmd_o.claim_wr = 1'b1;
        if (sts_i.claim_done) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_ERR_ZERO: begin
        if (sts_i.out_free) begin
          cmd_o.emit_zero = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_ERR_CAP: begin
        if (sts_i.out_free) begin
          cmd_o.emit_cap = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

// ===== design/rsa_dpath.sv =====
// Datapath: free-sector bitmap, slot table, scan counters and result register.
`default_nettype none
module rsa_dpath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [23:0]       in_data_i,
  input  wire rsa_pkg::rsa_cmd_t cmd_i,
  output rsa_pkg::rsa_sts_t      sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [15:0]            out_data_o
);
  import rsa_pkg::*;

  logic                 bm_mem [MaxSectors];
  logic [SecW+LenW-1:0] slot_mem [2**SlotW];

  logic                 bm_rd_q;
  logic [SecW+LenW-1:0] slot_rd_q;
  logic [SlotW-1:0]     idx_q;
  logic [LenW-1:0]      n_q, old_len_q;
  logic [SecW-1:0]      old_off_q, start_q;
  logic [ExtW-1:0]      s_q, used_q;
  logic [LenW-1:0]      run_q;
  logic                 ext_q;
  logic [SlotW-1:0]     clr_q;
  logic                 out_valid_q;
  logic [15:0]          out_data_q;

  logic [ExtW-1:0] s_inc, old_end, rel_addr, claim_addr;
  logic [LenW:0]   run_inc;
  logic            in_old, fr;
  logic [ExtW:0]   ext_sum;

  assign s_inc      = s_q + ExtW'(1);
  assign old_end    = ExtW'(old_off_q) + ExtW'(old_len_q);
  assign in_old     = (old_len_q != '0) && (old_off_q >= SecW'(FirstData)) &&
                      (s_q >= ExtW'(old_off_q)) && (s_q < old_end);
  assign fr         = bm_rd_q | in_old;
  assign run_inc    = {1'b0, run_q} + (LenW+1)'(1);
  assign ext_sum    = {1'b0, used_q} + (ExtW+1)'(n_q);
  assign rel_addr   = ExtW'(old_off_q) + s_q;
  assign claim_addr = ExtW'(start_q) + s_q;

  always_comb begin
    sts_o            = '0;
    sts_o.clr_done   = (clr_q == '1);
    sts_o.n_zero     = (in_data_i[17:10] == '0);
    sts_o.scan_empty = (used_q <= ExtW'(FirstData));
    sts_o.scan_last  = (s_inc >= used_q);
    sts_o.found_now  = fr && (run_inc == {1'b0, n_q});
    sts_o.cap_fail   = (ext_sum > (ExtW+1)'(MaxSectors));
    sts_o.rel_need   = (old_len_q != '0) && (old_off_q >= SecW'(FirstData));
    sts_o.rel_done   = (s_inc == ExtW'(old_len_q));
    sts_o.claim_done = (s_inc == ExtW'(n_q));
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Bitmap: one write port shared by release and claim, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rel_wr && (rel_addr < used_q)) bm_mem[rel_addr[SecW-1:0]] <= 1'b1;
    else if (cmd_i.claim_wr && (claim_addr < ExtW'(MaxSectors)))
      bm_mem[claim_addr[SecW-1:0]] <= 1'b0;
    if (cmd_i.scan_rd) bm_rd_q <= bm_mem[s_q[SecW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) slot_mem[clr_q] <= '0;
    else if (cmd_i.commit) slot_mem[idx_q] <= {start_q, n_q};
    if (cmd_i.slot_rd) slot_rd_q <= slot_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q <= {in_data_i[9:5], in_data_i[4:0]};
      n_q   <= in_data_i[17:10];
    end
    if (cmd_i.load_slot) begin
      old_off_q <= slot_rd_q[SecW+LenW-1:LenW];
      old_len_q <= slot_rd_q[LenW-1:0];
      s_q       <= ExtW'(FirstData);
      run_q     <= '0;
    end
    if (cmd_i.scan_step) begin
      run_q <= fr ? run_inc[LenW-1:0] : '0;
      if (sts_o.found_now) begin
        start_q <= SecW'(s_inc - ExtW'(n_q));
        ext_q   <= 1'b0;
        s_q     <= '0;
      end else begin
        s_q <= s_inc;
      end
    end
    if (cmd_i.decide) begin
      start_q <= used_q[SecW-1:0];
      ext_q   <= 1'b1;
      s_q     <= '0;
    end
    if (cmd_i.rel_wr) s_q <= sts_o.rel_done ? '0 : s_inc;
    if (cmd_i.claim_wr) s_q <= s_inc;
    if (cmd_i.commit)
      out_data_q <= {ST_OK, ext_q, (old_len_q != '0), start_q};
    else if (cmd_i.emit_zero) out_data_q <= {ST_ZERO, 14'd0};
    else if (cmd_i.emit_cap) out_data_q <= {ST_CAP, 14'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= ExtW'(FirstData);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + SlotW'(1);
      if (cmd_i.commit && ext_q) used_q <= ext_sum[ExtW-1:0];
      if (cmd_i.commit || cmd_i.emit_zero || cmd_i.emit_cap) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
endmodule
`default_nettype wire

// ===== design/region_sector_allocator.sv =====
// Top level of the first-fit contiguous sector allocator.
//
//  Port group   Dir  Payload (tdata, low bit first)
//  s_axis       in   slot_x[4:0] slot_z[9:5] sectors_needed[17:10] zero[23:18]
//  m_axis       out  start_sector[11:0] replaced_old[12] extended[13] status[15:14]
//
// One request at a time. After the slot lookup, a request reads then checks the bitmap for
// each scanned sector of the used extent, then releases the slot's old run, if any, and claims
// the new run sector by sector before the commit; the single bitmap port serialises these steps.
// A zero count is answered without lookup or scan. After reset the slot table is cleared,
// during which no request is taken. A stalled result holds the next commit.
`default_nettype none
module region_sector_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // slot_x, slot_z, sectors_needed, zero fill
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o    // start_sector, replaced_old, extended, status
);
  import rsa_pkg::*;

  rsa_cmd_t cmd;
  rsa_sts_t sts;

  rsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rsa_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );
endmodule
`default_nettype wire

// ===== design/rsa_checker.sv =====
// Port-level checks of the sector allocator and their binding.
`default_nettype none
module rsa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o
);
  import rsa_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[15:14] == ST_OK) ||
      (m_axis_tdata_o[15:14] == ST_ZERO) || (m_axis_tdata_o[15:14] == ST_CAP))
    else $error("bad status code");

  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[15:14] != ST_OK) |-> m_axis_tdata_o[13:0] == '0)
    else $error("error result carries data");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[15:14] == ST_OK) |-> m_axis_tdata_o[11:0] >= 12'd2)
    else $error("run starts in header");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second request taken back to back");
endmodule

bind region_sector_allocator rsa_checker u_rsa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire

// ===== test/region_sector_allocator_chk.sv =====
// Checker for the region sector allocator: predicts every request and compares results.
`default_nettype none
module region_sector_allocator_chk (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [23:0] s_axis_tdata_i,   // slot_x, slot_z, sectors_needed, zero fill
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [15:0] m_axis_tdata_i,   // start_sector, replaced_old, extended, status
  output int               fail_count_o,
  output int               outstanding_o
);
  import rsa_pkg::*;

  typedef struct packed {
    logic [1:0]      status;
    logic            extended;
    logic            replaced_old;
    logic [SecW-1:0] start_sector;
  } alloc_res_t;

  logic            free_map [MaxSectors];
  logic [SecW-1:0] run_off  [1024];
  logic [LenW-1:0] run_len  [1024];
  int unsigned     extent;
  alloc_res_t      alloc_q [$];

  function automatic alloc_res_t allocate(logic [4:0] x, logic [4:0] z, logic [7:0] n);
    alloc_res_t  r;
    int unsigned idx, old_off, old_len, run, s, start;
    bit          found, fr;
    r = '0;
    found = 0;
    run = 0;
    start = 0;
    if (n == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    idx = {z, x};
    old_off = run_off[idx];
    old_len = run_len[idx];
    for (s = FirstData; s < extent && s < MaxSectors; s++) begin
      fr = free_map[s];
      // The slot's own run may be reused by the new allocation.
      if (old_len != 0 && old_off >= FirstData && s >= old_off && s - old_off < old_len)
        fr = 1;
      run = fr ? run + 1 : 0;
      if (run == n) begin
        start = s + 1 - n;
        found = 1;
        break;
      end
    end
    if (!found) begin
      if (extent + n > MaxSectors) begin
        r.status = ST_CAP;
        return r;
      end
      start = extent;
      r.extended = 1'b1;
    end
    if (old_len != 0 && old_off >= FirstData) begin
      for (s = old_off; s < old_off + old_len; s++)
        if (s < extent && s < MaxSectors) free_map[s] = 1'b1;
    end
    if (r.extended) extent += n;
    for (s = start; s < start + n; s++)
      if (s < MaxSectors) free_map[s] = 1'b0;
    run_off[idx] = SecW'(start);
    run_len[idx] = n;
    r.start_sector = SecW'(start);
    r.replaced_old = (old_len != 0);
    r.status = ST_OK;
    return r;
  endfunction

  initial begin
    for (int i = 0; i < MaxSectors; i++) free_map[i] = 1'b0;
    for (int i = 0; i < 1024; i++) begin
      run_off[i] = '0;
      run_len[i] = '0;
    end
    extent = FirstData;
    fail_count_o = 0;
    outstanding_o = 0;
  end

  always @(posedge clk_i) begin
    alloc_res_t want, got;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        alloc_q.insert(alloc_q.size(), allocate(s_axis_tdata_i[4:0], s_axis_tdata_i[9:5],
                                                s_axis_tdata_i[17:10]));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i;
        if (alloc_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata_i);
          fail_count_o++;
        end else begin
          want = alloc_q.pop_front();
          if (got.start_sector !== want.start_sector) begin
            $display("%0t: start_sector expected %0d actual %0d", $time,
                     want.start_sector, got.start_sector);
            fail_count_o++;
          end
          if (got.replaced_old !== want.replaced_old) begin
            $display("%0t: replaced_old expected %0d actual %0d", $time,
                     want.replaced_old, got.replaced_old);
            fail_count_o++;
          end
          if (got.extended !== want.extended) begin
            $display("%0t: extended expected %0d actual %0d", $time,
                     want.extended, got.extended);
            fail_count_o++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, got.status);
            fail_count_o++;
          end
        end
      end
      outstanding_o = alloc_q.size();
    end
  end

endmodule
`default_nettype wire

// ===== test/region_sector_allocator_tb.sv =====
// Testbench top for the region sector allocator: stimulus, receiver stalls and verdict.
`default_nettype none
module region_sector_allocator_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  int          fail_count;
  int          outstanding;
  int          burst_left = 0;
  logic [9:0]  slot_pool [16];

  always #4 clk_i = ~clk_i;

  region_sector_allocator i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  region_sector_allocator_chk i_chk (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  // The receiver switches between always ready, coin flip and mostly stalled.
  always @(posedge clk_i) begin
    int unsigned mode_left, mode;
    if (mode_left == 0) begin
      mode = $urandom_range(0, 2);
      mode_left = $urandom_range(16, 200);
    end
    mode_left--;
    case (mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_request(logic [4:0] x, logic [4:0] z, logic [7:0] n);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, n, z, x};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    logic [9:0] slot;
    int unsigned pick;
    logic [7:0] n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 16; i++) slot_pool[i] = 10'($urandom_range(0, 1023));

    // Directed: zero count, extremes, reuse of the slot's own run, filling a hole.
    send_request(5'd0, 5'd0, 8'd0);
    send_request(5'd31, 5'd31, 8'd255);
    send_request(5'd0, 5'd0, 8'd1);
    send_request(5'd31, 5'd31, 8'd128);
    send_request(5'd5, 5'd10, 8'd100);
    send_request(5'd31, 5'd31, 8'd0);
    send_request(5'd31, 5'd0, 8'd1);
    send_request(5'd0, 5'd31, 8'd170);
    send_request(5'd21, 5'd10, 8'd85);
    send_request(5'd10, 5'd21, 8'd3);
    send_request(5'd0, 5'd0, 8'd1);
    send_request(5'd0, 5'd31, 8'd2);
    drain();

    // Random part: mostly rewrites of a small slot pool so the used area stays short.
    for (int i = 0; i < 1850; i++) begin
      pick = $urandom_range(0, 99);
      slot = (pick < 88) ? slot_pool[$urandom_range(0, 15)] : 10'($urandom_range(0, 1023));
      if (pick % 20 == 7) n = 8'd0;
      else if (pick % 33 == 5) n = 8'($urandom_range(13, 64));
      else n = 8'($urandom_range(1, 12));
      send_request(slot[4:0], slot[9:5], n);
      if (i == 900) drain();
    end

    // Fill the region up to capacity, then try runs of random size against it.
    for (int i = 0; i < 20; i++) send_request(5'(i), 5'd17, 8'd255);
    for (int i = 0; i < 12; i++)
      send_request(5'($urandom_range(0, 31)), 5'd18, 8'($urandom_range(1, 255)));
    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("region_sector_allocator test passed");
    else $display("region_sector_allocator test failed");
    $finish;
  end

  initial begin
    #1000000000;
    $display("region_sector_allocator test failed");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
design/rsa_pkg.sv
design/rsa_ctrl.sv
design/rsa_dpath.sv
design/region_sector_allocator.sv
design/rsa_checker.sv
test/region_sector_allocator_chk.sv
test/region_sector_allocator_tb.sv
